>>> sv/i2cbe_pkg.sv
// i2cbe_pkg: shared codes, sizes and the queued item type of the I2C bit engine.
// No dependencies; used by every module of the engine.
package i2cbe_pkg;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_ACK   = 3'd5;

	localparam logic [2:0] PH_0      = 3'd0;
	localparam logic [2:0] PH_1      = 3'd1;
	localparam logic [2:0] PH_2      = 3'd2;
	localparam logic [2:0] PH_3      = 3'd3;
	localparam logic [2:0] PH_4      = 3'd4;
	localparam logic [2:0] PH_5      = 3'd5;
	localparam logic [2:0] PH_FINISH = 3'd7;

	localparam logic [15:0] DELAY_RESET = 16'd62;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0] cmd;
		logic       has_cmd;
		logic       legal;
		logic [7:0] data_byte;
		logic       ack_level;
		logic       sda_in;
	} item_t;

endpackage

>>> sv/i2cbe_front.sv
// i2cbe_front: takes input transfers and classifies the command code.
// Depends on i2cbe_pkg; feeds i2cbe_queue.
module i2cbe_front
	import i2cbe_pkg::*;
(
	input  logic       in_valid,
	input  logic [2:0] cmd,
	input  logic [7:0] data_byte,
	input  logic       ack_level,
	input  logic       sda_in,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	always_comb begin
		push_item.cmd       = cmd;
		push_item.has_cmd   = (cmd != CMD_NONE);
		push_item.legal     = cmd inside {[CMD_START:CMD_ACK]};
		push_item.data_byte = data_byte;
		push_item.ack_level = ack_level;
		push_item.sda_in    = sda_in;
	end

	assign push = in_valid & ~q_full;

endmodule

>>> sv/i2cbe_queue.sv
// i2cbe_queue: short register queue between classifier and sequencer.
// Depends on i2cbe_pkg.
module i2cbe_queue
	import i2cbe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output item_t head
);

	item_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/i2cbe_seq.sv
// i2cbe_seq: bus sequencer, one queued tick per cycle while out_stall allows, with output register.
// Depends on i2cbe_pkg; holds the edge delay register.
module i2cbe_seq
	import i2cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        q_not_empty,
	input  item_t       q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_value,
	output logic        ack_seen,
	output logic        cmd_rejected
);

	logic [15:0] dly_q;
	logic [2:0]  act_q, n_act;
	logic [2:0]  ph_q, n_ph;
	logic [3:0]  bidx_q, n_bidx;
	logic [7:0]  sh_q, n_sh;
	logic [15:0] wc_q, n_wc;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        drv_q, n_drv;
	logic        ack_q, n_ack;
	logic [7:0]  rhold_q, n_rhold;
	logic        n_done, n_rej;
	logic        run, adv, adv_dly, adv_last, fin;
	logic [2:0]  adv_next;
	logic [15:0] wc_dec;

	logic        out_valid_q, done_q, rej_q;

	assign pop    = q_not_empty & (~out_valid_q | ~out_stall);
	assign wc_dec = wc_q - 16'd1;

	always_comb begin
		n_act = act_q; n_ph = ph_q; n_bidx = bidx_q; n_sh = sh_q; n_wc = wc_q;
		n_scl = scl_q; n_sda = sda_q; n_drv = drv_q; n_ack = ack_q; n_rhold = rhold_q;
		n_done = 1'b0; n_rej = 1'b0;
		run = 1'b0; adv = 1'b0; adv_dly = 1'b0; adv_last = 1'b0; fin = 1'b0;
		adv_next = PH_0;

		if (act_q == CMD_NONE) begin
			if (q_head.legal) begin
				n_act  = q_head.cmd;
				n_ph   = PH_0;
				n_bidx = '0;
				n_wc   = '0;
				if (q_head.cmd == CMD_WRITE) begin
					n_sh = q_head.data_byte;
				end else if (q_head.cmd == CMD_ACK) begin
					n_sh = {7'd0, q_head.ack_level};
				end else if (q_head.cmd == CMD_READ) begin
					n_sh = '0;
				end
				run = 1'b1;
			end else begin
				n_rej = q_head.has_cmd;
			end
		end else begin
			n_rej = q_head.has_cmd;
			if (wc_q != '0) begin
				n_wc = wc_dec;
				if (wc_dec == '0 && ph_q == PH_FINISH) begin
					fin = 1'b1;
				end
			end else begin
				run = 1'b1;
			end
		end

		if (run) begin
			case (n_act)
				CMD_START: begin
					case (n_ph)
						PH_0: begin
							n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						PH_1: begin
							n_sda = 1'b0; adv = 1'b1; adv_next = PH_2; adv_dly = 1'b1;
						end
						PH_2: begin
							n_scl = 1'b0; adv = 1'b1; adv_dly = 1'b1; adv_last = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
				CMD_STOP: begin
					case (n_ph)
						PH_0: begin
							n_drv = 1'b1; n_sda = 1'b0;
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						PH_1: begin
							n_scl = 1'b1; adv = 1'b1; adv_next = PH_2; adv_dly = 1'b1;
						end
						PH_2: begin
							n_sda = 1'b1; adv = 1'b1; adv_dly = 1'b1; adv_last = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
				CMD_ACK: begin
					case (n_ph)
						PH_0: begin
							n_drv = 1'b1; n_sda = n_sh[0];
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						PH_1: begin
							n_scl = 1'b1; adv = 1'b1; adv_next = PH_2; adv_dly = 1'b1;
						end
						PH_2: begin
							n_scl = 1'b0; adv = 1'b1; adv_dly = 1'b1; adv_last = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
				CMD_WRITE: begin
					case (n_ph)
						PH_0: begin
							n_drv = 1'b1; n_sda = n_sh[7];
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						PH_1: begin
							n_scl = 1'b1; adv = 1'b1; adv_next = PH_2; adv_dly = 1'b1;
						end
						PH_2: begin
							n_scl  = 1'b0;
							n_sh   = {n_sh[6:0], 1'b0};
							n_bidx = n_bidx + 4'd1;
							adv    = 1'b1;
							adv_next = n_bidx[3] ? PH_3 : PH_0;
						end
						PH_3: begin
							n_sda = 1'b1; n_drv = 1'b0;
							adv = 1'b1; adv_next = PH_4; adv_dly = 1'b1;
						end
						PH_4: begin
							n_scl = 1'b1; adv = 1'b1; adv_next = PH_5; adv_dly = 1'b1;
						end
						PH_5: begin
							n_ack = q_head.sda_in; n_scl = 1'b0;
							adv = 1'b1; adv_last = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
				CMD_READ: begin
					case (n_ph)
						PH_0: begin
							n_sda = 1'b1; n_drv = 1'b0;
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						PH_1: begin
							n_scl = 1'b1; adv = 1'b1; adv_next = PH_2; adv_dly = 1'b1;
						end
						PH_2: begin
							n_sh   = {n_sh[6:0], q_head.sda_in};
							n_scl  = 1'b0;
							n_bidx = n_bidx + 4'd1;
							adv    = 1'b1;
							adv_dly = 1'b1;
							adv_last = n_bidx[3];
							adv_next = (dly_q != '0) ? PH_3 : PH_1;
						end
						PH_3: begin
							adv = 1'b1; adv_next = PH_1; adv_dly = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
				default: fin = 1'b1;
			endcase
		end

		if (adv) begin
			n_wc = adv_dly ? dly_q : '0;
			if (adv_last) begin
				if (adv_dly && dly_q != '0) begin
					n_ph = PH_FINISH;
				end else begin
					fin = 1'b1;
				end
			end else begin
				n_ph = adv_next;
			end
		end

		if (fin) begin
			if (n_act == CMD_READ) begin
				n_rhold = n_sh;
			end
			n_act  = CMD_NONE;
			n_ph   = PH_0;
			n_wc   = '0;
			n_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q       <= DELAY_RESET;
			act_q       <= CMD_NONE;
			ph_q        <= PH_0;
			bidx_q      <= '0;
			sh_q        <= '0;
			wc_q        <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b1;
			ack_q       <= 1'b0;
			rhold_q     <= '0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				dly_q <= cfg_wdata;
			end
			if (pop) begin
				act_q   <= n_act;
				ph_q    <= n_ph;
				bidx_q  <= n_bidx;
				sh_q    <= n_sh;
				wc_q    <= n_wc;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				drv_q   <= n_drv;
				ack_q   <= n_ack;
				rhold_q <= n_rhold;
				done_q  <= n_done;
				rej_q   <= n_rej;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_level    = scl_q;
	assign sda_level    = sda_q;
	assign sda_drive    = drv_q;
	assign busy_res     = (act_q != CMD_NONE);
	assign done_res     = done_q;
	assign read_value   = rhold_q;
	assign ack_seen     = ack_q;
	assign cmd_rejected = rej_q;

`ifndef SYNTH
	a_wait_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(wc_q != '0) |-> (act_q != CMD_NONE))
		else $error("wait count running while idle");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_FINISH) |-> (wc_q != '0))
		else $error("finish phase without trailing wait");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (act_q == CMD_NONE))
		else $error("done reported while still busy");
`endif

endmodule

>>> sv/i2c_master_bit_engine_core.sv
// i2c_master_bit_engine_core: top level of the single-master I2C bit engine.
// Depends on i2cbe_pkg, i2cbe_front, i2cbe_queue and i2cbe_seq.
//
// channel | handshake          | payload
// in      | in_valid/in_stall  | cmd, data_byte, ack_level, sda_in (one bus tick)
// out     | out_valid/out_stall| scl_level, sda_level, sda_drive, busy_res,
//         |                    | done_res, read_value, ack_seen, cmd_rejected
// cfg     | cfg_we             | cfg_wdata (edge delay in ticks)
//
// One tick per cycle while out_stall is low; each input passes the queue, then the output register.
// The sequencer state is registered; a 4-entry queue decouples input and output.
// arst_n clears control state; delay register resets to 62 ticks, bus lines high.
// in_stall rises only when the queue is full; out_stall holds the output register.
module i2c_master_bit_engine_core
	import i2cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic        ack_level,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_value,
	output logic        ack_seen,
	output logic        cmd_rejected
);

	logic  push, pop, q_full, q_not_empty;
	item_t push_item, q_head;

	assign in_stall = q_full;

	i2cbe_front u_front (
		.in_valid  (in_valid),
		.cmd       (cmd),
		.data_byte (data_byte),
		.ack_level (ack_level),
		.sda_in    (sda_in),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	i2cbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	i2cbe_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_value   (read_value),
		.ack_seen     (ack_seen),
		.cmd_rejected (cmd_rejected)
	);

endmodule

>>> tb/sv/i2cbe_bus_checker.sv
// i2cbe_bus_checker: watches both channels and the delay register port of the I2C bit engine,
// predicts one bus result per accepted tick and compares it with what comes out.
// Depends on i2cbe_pkg for command and phase codes.
module i2cbe_bus_checker
	import i2cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic        ack_level,
	input  logic        sda_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        scl_level,
	input  logic        sda_level,
	input  logic        sda_drive,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [7:0]  read_value,
	input  logic        ack_seen,
	input  logic        cmd_rejected,
	output int          fail_count,
	output int          exp_count
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		logic [7:0] rdv;
		logic       ack;
		logic       rej;
	} bus_res_t;

	bus_res_t bus_exp_q[$];
	bus_res_t got_res;
	bus_res_t want_res;

	// sequencer copy
	logic [15:0] delay_r  = DELAY_RESET;
	logic [2:0]  cur_cmd  = CMD_NONE;
	logic [2:0]  phase    = PH_0;
	logic [3:0]  bit_cnt  = '0;
	logic [7:0]  shreg    = '0;
	logic [15:0] wait_cnt = '0;
	logic        scl_r    = 1'b1;
	logic        sda_r    = 1'b1;
	logic        drv_r    = 1'b1;
	logic        ack_r    = 1'b0;
	logic [7:0]  rd_hold  = '0;
	logic        done_r   = 1'b0;

	task automatic seq_reset();
		delay_r  = DELAY_RESET;
		cur_cmd  = CMD_NONE;
		phase    = PH_0;
		bit_cnt  = '0;
		shreg    = '0;
		wait_cnt = '0;
		scl_r    = 1'b1;
		sda_r    = 1'b1;
		drv_r    = 1'b1;
		ack_r    = 1'b0;
		rd_hold  = '0;
		done_r   = 1'b0;
	endtask

	function automatic void seq_finish();
		if (cur_cmd == CMD_READ)
			rd_hold = shreg;
		cur_cmd  = CMD_NONE;
		phase    = PH_0;
		wait_cnt = '0;
		done_r   = 1'b1;
	endfunction

	// move on to the next phase, loading the edge wait if asked; a last step with a
	// pending wait parks in the finish phase
	function automatic void seq_next(input logic [2:0] nxt, input bit dly, input bit last);
		wait_cnt = dly ? delay_r : 16'd0;
		if (last) begin
			if (wait_cnt != 16'd0)
				phase = PH_FINISH;
			else
				seq_finish();
		end else begin
			phase = nxt;
		end
	endfunction

	function automatic void seq_action(input logic s);
		case (cur_cmd)
			CMD_START: begin
				if (phase == PH_0) begin
					drv_r = 1'b1; sda_r = 1'b1; scl_r = 1'b1; seq_next(PH_1, 1'b1, 1'b0);
				end else if (phase == PH_1) begin
					sda_r = 1'b0; seq_next(PH_2, 1'b1, 1'b0);
				end else if (phase == PH_2) begin
					scl_r = 1'b0; seq_next(PH_0, 1'b1, 1'b1);
				end else begin
					seq_finish();
				end
			end
			CMD_STOP: begin
				if (phase == PH_0) begin
					drv_r = 1'b1; sda_r = 1'b0; seq_next(PH_1, 1'b1, 1'b0);
				end else if (phase == PH_1) begin
					scl_r = 1'b1; seq_next(PH_2, 1'b1, 1'b0);
				end else if (phase == PH_2) begin
					sda_r = 1'b1; seq_next(PH_0, 1'b1, 1'b1);
				end else begin
					seq_finish();
				end
			end
			CMD_ACK: begin
				if (phase == PH_0) begin
					drv_r = 1'b1; sda_r = shreg[0]; seq_next(PH_1, 1'b1, 1'b0);
				end else if (phase == PH_1) begin
					scl_r = 1'b1; seq_next(PH_2, 1'b1, 1'b0);
				end else if (phase == PH_2) begin
					scl_r = 1'b0; seq_next(PH_0, 1'b1, 1'b1);
				end else begin
					seq_finish();
				end
			end
			CMD_WRITE: begin
				if (phase == PH_0) begin
					drv_r = 1'b1; sda_r = shreg[7]; seq_next(PH_1, 1'b1, 1'b0);
				end else if (phase == PH_1) begin
					scl_r = 1'b1; seq_next(PH_2, 1'b1, 1'b0);
				end else if (phase == PH_2) begin
					scl_r   = 1'b0;
					shreg   = {shreg[6:0], 1'b0};
					bit_cnt = bit_cnt + 4'd1;
					seq_next((bit_cnt >= 4'd8) ? PH_3 : PH_0, 1'b0, 1'b0);
				end else if (phase == PH_3) begin
					sda_r = 1'b1; drv_r = 1'b0; seq_next(PH_4, 1'b1, 1'b0);
				end else if (phase == PH_4) begin
					scl_r = 1'b1; seq_next(PH_5, 1'b1, 1'b0);
				end else if (phase == PH_5) begin
					ack_r = s; scl_r = 1'b0; seq_next(PH_0, 1'b0, 1'b1);
				end else begin
					seq_finish();
				end
			end
			CMD_READ: begin
				if (phase == PH_0) begin
					sda_r = 1'b1; drv_r = 1'b0; seq_next(PH_1, 1'b1, 1'b0);
				end else if (phase == PH_1) begin
					scl_r = 1'b1; seq_next(PH_2, 1'b1, 1'b0);
				end else if (phase == PH_2) begin
					shreg   = {shreg[6:0], s};
					scl_r   = 1'b0;
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= 4'd8)
						seq_next(PH_0, 1'b1, 1'b1);
					else
						seq_next((delay_r != 16'd0) ? PH_3 : PH_1, 1'b1, 1'b0);
				end else if (phase == PH_3) begin
					seq_next(PH_1, 1'b1, 1'b0);
				end else begin
					seq_finish();
				end
			end
			default: seq_finish();
		endcase
	endfunction

	function automatic bus_res_t engine_tick(input logic [2:0] c, input logic [7:0] d,
			input logic a, input logic s);
		logic rej;
		rej    = 1'b0;
		done_r = 1'b0;
		if (cur_cmd == CMD_NONE) begin
			if (c >= CMD_START && c <= CMD_ACK) begin
				cur_cmd  = c;
				phase    = PH_0;
				bit_cnt  = '0;
				wait_cnt = '0;
				if (c == CMD_WRITE)
					shreg = d;
				else if (c == CMD_ACK)
					shreg = {7'd0, a};
				else if (c == CMD_READ)
					shreg = '0;
				seq_action(s);
			end else if (c != CMD_NONE) begin
				rej = 1'b1;
			end
		end else begin
			if (c != CMD_NONE)
				rej = 1'b1;
			if (wait_cnt != 16'd0) begin
				wait_cnt = wait_cnt - 16'd1;
				if (wait_cnt == 16'd0 && phase == PH_FINISH)
					seq_finish();
			end else begin
				seq_action(s);
			end
		end
		return {scl_r, sda_r, drv_r, cur_cmd != CMD_NONE, done_r, rd_hold, ack_r, rej};
	endfunction

	function automatic string res_str(input bus_res_t r);
		return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b rd=%h ack=%b rej=%b",
			r.scl, r.sda, r.drv, r.busy, r.done, r.rdv, r.ack, r.rej);
	endfunction

	task automatic flag_fail(input string why, input bus_res_t want, input bus_res_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: exp %s | got %s", $time, why, res_str(want), res_str(got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_reset();
			bus_exp_q.delete();
			exp_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_res = {scl_level, sda_level, sda_drive, busy_res, done_res,
					read_value, ack_seen, cmd_rejected};
				if (bus_exp_q.size() == 0) begin
					flag_fail("result with nothing outstanding", '0, got_res);
				end else begin
					want_res = bus_exp_q.pop_front();
					if (got_res !== want_res)
						flag_fail("result mismatch", want_res, got_res);
				end
			end
			if (cfg_we)
				delay_r = cfg_wdata;
			if (in_valid && !in_stall)
				bus_exp_q.push_back(engine_tick(cmd, data_byte, ack_level, sda_in));
			exp_count = bus_exp_q.size();
		end
	end

endmodule

>>> tb/sv/i2c_master_bit_engine_core_tb.sv
// i2c_master_bit_engine_core_tb: drives bus ticks and delay settings into the I2C bit engine,
// with random gaps and stalls on both channels, and gives the verdict.
// Depends on i2cbe_pkg, i2c_master_bit_engine_core and i2cbe_bus_checker.
module i2c_master_bit_engine_core_tb;
	import i2cbe_pkg::*;

	localparam logic [2:0] CMD_BAD6 = 3'd6;
	localparam logic [2:0] CMD_BAD7 = 3'd7;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd       = CMD_NONE;
	logic [7:0]  data_byte = '0;
	logic        ack_level = 1'b0;
	logic        sda_in    = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        sda_drive;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_value;
	logic        ack_seen;
	logic        cmd_rejected;

	int fail_count;
	int exp_count;
	int sent_ticks = 0;
	int cur_delay  = 62;
	int calm_tx    = 0;
	bit pressure_done = 1'b0;

	i2c_master_bit_engine_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.ack_level    (ack_level),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_value   (read_value),
		.ack_seen     (ack_seen),
		.cmd_rejected (cmd_rejected)
	);

	i2cbe_bus_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.ack_level    (ack_level),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_value   (read_value),
		.ack_seen     (ack_seen),
		.cmd_rejected (cmd_rejected),
		.fail_count   (fail_count),
		.exp_count    (exp_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// mostly short gaps, now and then a long one, and calm stretches with none
	function automatic int tx_gap();
		int r;
		if (calm_tx > 0) begin
			calm_tx--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm_tx = 100;
		if (r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// rough upper bound on the ticks one command occupies at delay d
	function automatic int seq_len(input logic [2:0] c, input int d);
		case (c)
			CMD_WRITE: return 8 * (2 * d + 3) + 2 * d + 4;
			CMD_READ:  return 8 * (3 * d + 3) + d + 2;
			default:   return 3 * d + 4;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send(input logic [2:0] c, input logic [7:0] d, input logic a,
			input logic s);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		data_byte <= d;
		ack_level <= a;
		sda_in    <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_ticks++;
		@(negedge clk);
	endtask

	// sda_mode: 0 or 1 holds SDA at that level, anything else randomises it
	task automatic idle_ticks(input int n, input int sda_mode);
		repeat (n)
			send(CMD_NONE, 8'($urandom), 1'($urandom), (sda_mode == 0 || sda_mode == 1) ?
				sda_mode[0] : 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (exp_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_delay(input logic [15:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_delay = int'(v);
	endtask

	// command sequences with random content; some cut short so the next one lands busy
	task automatic traffic(input int n);
		int first;
		int r;
		int pad;
		logic [2:0] c;
		first = sent_ticks;
		while (sent_ticks - first < n) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				c = CMD_START;
			else if (r < 24)
				c = CMD_STOP;
			else if (r < 55)
				c = CMD_WRITE;
			else if (r < 75)
				c = CMD_READ;
			else if (r < 93)
				c = CMD_ACK;
			else
				c = $urandom_range(0, 1) ? CMD_BAD6 : CMD_BAD7;
			send(c, 8'($urandom), 1'($urandom), 1'($urandom));
			pad = seq_len(c, cur_delay) - 1 + $urandom_range(0, 2);
			if ($urandom_range(0, 99) < 15)
				pad = $urandom_range(0, pad / 2);
			idle_ticks(pad, 2);
		end
	endtask

	// receiver: random stalls, and once a long hold to back the queue up
	initial begin
		int stall_left;
		int calm_rx;
		int r;
		stall_left = 0;
		calm_rx    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressure_done && sent_ticks >= 600) begin
				pressure_done = 1'b1;
				stall_left    = 80;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (calm_rx > 0) begin
				calm_rx--;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					calm_rx = 150;
					out_stall <= 1'b0;
				end else if (r < 65) begin
					out_stall <= 1'b0;
				end else if (r < 90) begin
					stall_left = $urandom_range(0, 2);
					out_stall <= 1'b1;
				end else if (r < 97) begin
					stall_left = $urandom_range(3, 10);
					out_stall <= 1'b1;
				end else begin
					stall_left = $urandom_range(15, 40);
					out_stall <= 1'b1;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset delay: start with a busy attempt, then stop
		send(CMD_START, 8'h00, 1'b0, 1'b1);
		idle_ticks(30, 2);
		send(CMD_WRITE, 8'h5A, 1'b1, 1'b0);
		idle_ticks(170, 2);
		send(CMD_STOP, 8'hFF, 1'b1, 1'b1);
		idle_ticks(195, 2);

		// no-delay build: every command, byte extremes, ack and nack
		set_delay(16'd0);
		send(CMD_START, 8'h00, 1'b0, 1'b1);
		idle_ticks(3, 2);
		send(CMD_WRITE, 8'hFF, 1'b0, 1'b1);
		idle_ticks(28, 0);
		send(CMD_WRITE, 8'h00, 1'b1, 1'b0);
		idle_ticks(28, 1);
		send(CMD_WRITE, 8'hA5, 1'b0, 1'b0);
		idle_ticks(28, 2);
		send(CMD_READ, 8'h00, 1'b0, 1'b1);
		idle_ticks(25, 1);
		send(CMD_READ, 8'hFF, 1'b1, 1'b0);
		idle_ticks(25, 0);
		send(CMD_READ, 8'h00, 1'b0, 1'b1);
		idle_ticks(25, 2);
		send(CMD_ACK, 8'h00, 1'b0, 1'b1);
		idle_ticks(4, 2);
		send(CMD_ACK, 8'hFF, 1'b1, 1'b0);
		idle_ticks(4, 2);
		send(CMD_BAD6, 8'h12, 1'b0, 1'b1);
		send(CMD_BAD7, 8'h34, 1'b1, 1'b0);
		send(CMD_WRITE, 8'h3C, 1'b0, 1'b1);
		send(CMD_READ, 8'hC3, 1'b1, 1'b0);
		send(CMD_ACK, 8'h00, 1'b1, 1'b1);
		idle_ticks(28, 2);
		send(CMD_STOP, 8'h00, 1'b0, 1'b1);
		idle_ticks(4, 2);

		// delay changed while a wait is running: the loaded count stands
		set_delay(16'd20);
		send(CMD_START, 8'h00, 1'b0, 1'b1);
		idle_ticks(5, 2);
		set_delay(16'd0);
		idle_ticks(70, 2);

		set_delay(16'd1);
		traffic(180);
		set_delay(16'd0);
		traffic(180);
		set_delay(16'd2);
		traffic(180);
		set_delay(16'd3);
		traffic(170);
		set_delay(16'd0);
		traffic(170);
		set_delay(16'd7);
		traffic(160);

		// widest delay: only the first wait is seen, every command after it is refused
		set_delay(16'hFFFF);
		send(CMD_START, 8'h00, 1'b0, 1'b1);
		repeat (100)
			send(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && exp_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
